[sv/vcc3d_pkg.sv]
// Package for the 3D voxel connected-component labeller.
// Holds default grid sizes, the label cap, the state and op types and the cfg addresses.
// No dependencies.
package vcc3d_pkg;

  localparam int DEF_GRID_X  = 16;
  localparam int DEF_GRID_Y  = 16;
  localparam int DEF_GRID_Z  = 16;
  localparam int LABEL_LIMIT = 255;
  localparam int LABEL_W     = 8;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_POP,
    ST_POP_WAIT,
    ST_NBR,
    ST_NBR_CHK
  } vcc_state_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } vcc_op_t;

  localparam logic CFG_CONN26 = 1'b0;
  localparam logic CFG_MAXCMP = 1'b1;

endpackage

[sv/vcc3d_nbr.sv]
// Neighbour address generator for the labeller.
// Turns a voxel's coordinates and a neighbour offset into a grid address.
// Depends on vcc3d_pkg.
module vcc3d_nbr #(
  parameter int GRID_X = vcc3d_pkg::DEF_GRID_X,
  parameter int GRID_Y = vcc3d_pkg::DEF_GRID_Y,
  parameter int GRID_Z = vcc3d_pkg::DEF_GRID_Z,
  parameter int XW     = $clog2(GRID_X),
  parameter int YW     = $clog2(GRID_Y),
  parameter int ZW     = $clog2(GRID_Z),
  parameter int AW     = $clog2(GRID_X * GRID_Y * GRID_Z)
) (
  input  logic [XW-1:0] px,
  input  logic [YW-1:0] py,
  input  logic [ZW-1:0] pz,
  input  logic [1:0]    dx,
  input  logic [1:0]    dy,
  input  logic [1:0]    dz,
  input  logic          conn26,
  output logic          ok,
  output logic [XW-1:0] nx,
  output logic [YW-1:0] ny,
  output logic [ZW-1:0] nz,
  output logic [AW-1:0] n_idx
);
  import vcc3d_pkg::*;

  logic       out_x, out_y, out_z;
  logic [1:0] span;

  always_comb begin
    out_x = (dx == 2'd0 && px == '0) || (dx == 2'd2 && px == XW'(GRID_X - 1));
    out_y = (dy == 2'd0 && py == '0) || (dy == 2'd2 && py == YW'(GRID_Y - 1));
    out_z = (dz == 2'd0 && pz == '0) || (dz == 2'd2 && pz == ZW'(GRID_Z - 1));
    nx = (dx == 2'd0) ? px - 1'b1 : (dx == 2'd2) ? px + 1'b1 : px;
    ny = (dy == 2'd0) ? py - 1'b1 : (dy == 2'd2) ? py + 1'b1 : py;
    nz = (dz == 2'd0) ? pz - 1'b1 : (dz == 2'd2) ? pz + 1'b1 : pz;
    span = 2'(dx != 2'd1) + 2'(dy != 2'd1) + 2'(dz != 2'd1);
    ok = !out_x && !out_y && !out_z && (span != 2'd0) && (conn26 || span == 2'd1);
    n_idx = AW'(nx) + AW'(GRID_X) * (AW'(ny) + AW'(GRID_Y) * AW'(nz));
  end

endmodule

[sv/voxel_connected_components_3d.sv]
// Top level of the 3D voxel connected-component labeller.
// Holds occupancy, label and walk-queue memories and the controller.
// Depends on vcc3d_pkg and vcc3d_nbr.
//
// Usage: raise start with operation, voxel_index and occupied while busy is
// low; the beat is taken at that edge. A write beat stores one solid flag and
// gives no result. A read beat holds busy high for one cycle and its result
// appears in the first cycle with busy low again, marked by result_valid for
// one cycle. A run beat clears the labels, scans the voxels in raster order
// until done or until the component limit overflows, and walks each new
// component breadth-first from the queue, trying every neighbour offset of
// each popped voxel. The run result then appears with result_valid for one
// cycle; the receiver cannot stall, so results are never held. Configuration
// writes (cfg_wr_en) are taken at any edge and are meant only while idle.
// Reset clears the controller and starts a clearing pass over the occupancy
// memory with busy high; labels read as zero until a run completes without
// overflow.
module voxel_connected_components_3d #(
  parameter int GRID_X = vcc3d_pkg::DEF_GRID_X,
  parameter int GRID_Y = vcc3d_pkg::DEF_GRID_Y,
  parameter int GRID_Z = vcc3d_pkg::DEF_GRID_Z
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation,
  input  logic [11:0] voxel_index,
  input  logic       occupied,
  input  logic       cfg_wr_en,
  input  logic       cfg_addr,
  input  logic [7:0] cfg_wdata,
  output logic       result_valid,
  output logic [7:0] label,
  output logic [7:0] component_count,
  output logic       too_many,
  output logic       is_run_result
);
  import vcc3d_pkg::*;

  localparam int TOTAL = GRID_X * GRID_Y * GRID_Z;
  localparam int AW    = $clog2(TOTAL);
  localparam int XW    = $clog2(GRID_X);
  localparam int YW    = $clog2(GRID_Y);
  localparam int ZW    = $clog2(GRID_Z);
  localparam int QW    = XW + YW + ZW;
  localparam int CAP   = (LABEL_LIMIT < 255) ? LABEL_LIMIT : 255;

  // memories
  logic               occ_mem [TOTAL];
  logic [LABEL_W-1:0] lbl_mem [TOTAL];
  logic [QW-1:0]      q_mem   [TOTAL];

  logic               occ_we, lbl_we, q_we;
  logic [AW-1:0]      occ_wa, occ_ra, lbl_wa, lbl_ra, q_wa, q_ra;
  logic               occ_wd, occ_rd;
  logic [LABEL_W-1:0] lbl_wd, lbl_rd;
  logic [QW-1:0]      q_wd, q_rd;

  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[occ_wa] <= occ_wd;
    occ_rd <= occ_mem[occ_ra];
  end

  always_ff @(posedge clk) begin
    if (lbl_we) lbl_mem[lbl_wa] <= lbl_wd;
    lbl_rd <= lbl_mem[lbl_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd <= q_mem[q_ra];
  end

  // registers
  vcc_state_t         state, state_next;
  logic               conn26;
  logic [7:0]         max_cmp;
  logic [AW-1:0]      s, s_next;
  logic [XW-1:0]      sx, sx_next, px, px_next;
  logic [YW-1:0]      sy, sy_next, py, py_next;
  logic [ZW-1:0]      sz, sz_next, pz, pz_next;
  logic [1:0]         dx, dx_next, dy, dy_next, dz, dz_next;
  logic [AW:0]        head, head_next, tail, tail_next;
  logic [LABEL_W-1:0] found, found_next;
  logic               ovf, ovf_next, lbl_valid, lbl_valid_next;
  logic               rd_ok, rd_ok_next;
  logic               res_v_next, res_run_next, res_tm_next;
  logic [7:0]         res_lbl_next, res_cnt_next;

  logic [7:0]         lim;
  logic               n_ok;
  logic [XW-1:0]      nx;
  logic [YW-1:0]      ny;
  logic [ZW-1:0]      nz;
  logic [AW-1:0]      n_idx;
  logic               idx_ok;
  logic               s_last, nbr_last;

  vcc3d_nbr #(
    .GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z),
    .XW(XW), .YW(YW), .ZW(ZW), .AW(AW)
  ) u_nbr (
    .px(px), .py(py), .pz(pz), .dx(dx), .dy(dy), .dz(dz), .conn26(conn26),
    .ok(n_ok), .nx(nx), .ny(ny), .nz(nz), .n_idx(n_idx)
  );

  assign busy = (state != ST_IDLE);

  always_comb begin
    lim = (max_cmp == 8'd0) ? 8'd1 : max_cmp;
    if (32'(lim) > CAP) lim = 8'(CAP);
    idx_ok   = 32'(voxel_index) < 32'(TOTAL);
    s_last   = (s == AW'(TOTAL - 1));
    nbr_last = (dx == 2'd2) && (dy == 2'd2) && (dz == 2'd2);
  end

  always_comb begin
    state_next     = state;
    s_next         = s;
    sx_next        = sx;
    sy_next        = sy;
    sz_next        = sz;
    px_next        = px;
    py_next        = py;
    pz_next        = pz;
    dx_next        = dx;
    dy_next        = dy;
    dz_next        = dz;
    head_next      = head;
    tail_next      = tail;
    found_next     = found;
    ovf_next       = ovf;
    lbl_valid_next = lbl_valid;
    rd_ok_next     = rd_ok;
    res_v_next     = 1'b0;
    res_run_next   = 1'b0;
    res_tm_next    = ovf;
    res_lbl_next   = '0;
    res_cnt_next   = found;
    occ_we = 1'b0;
    occ_wa = AW'(voxel_index);
    occ_wd = occupied;
    occ_ra = s;
    lbl_we = 1'b0;
    lbl_wa = s;
    lbl_wd = '0;
    lbl_ra = s;
    q_we   = 1'b0;
    q_wa   = tail[AW-1:0];
    q_wd   = {nz, ny, nx};
    q_ra   = head[AW-1:0];

    case (state)
      ST_INIT: begin
        // empty the occupancy memory after reset
        occ_we = 1'b1;
        occ_wa = s;
        occ_wd = 1'b0;
        if (s_last) begin
          s_next     = '0;
          state_next = ST_IDLE;
        end else begin
          s_next = s + 1'b1;
        end
      end
      ST_IDLE: begin
        lbl_ra = AW'(voxel_index);
        if (start) begin
          case (operation)
            OP_WRITE: begin
              occ_we = idx_ok;
            end
            OP_RUN: begin
              s_next         = '0;
              lbl_valid_next = 1'b0;
              state_next     = ST_CLEAR;
            end
            OP_READ: begin
              rd_ok_next = idx_ok;
              state_next = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        res_v_next   = 1'b1;
        res_lbl_next = (lbl_valid && rd_ok) ? lbl_rd : '0;
        state_next   = ST_IDLE;
      end
      ST_CLEAR: begin
        lbl_we = 1'b1;
        if (s_last) begin
          s_next     = '0;
          sx_next    = '0;
          sy_next    = '0;
          sz_next    = '0;
          found_next = '0;
          ovf_next   = 1'b0;
          state_next = ST_SCAN;
        end else begin
          s_next = s + 1'b1;
        end
      end
      ST_SCAN: begin
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK, ST_POP: begin
        if (state == ST_SCAN_CHK && occ_rd && lbl_rd == '0) begin
          if (found >= lim) begin
            // overflow: leave every label invalid and report zero
            ovf_next     = 1'b1;
            found_next   = '0;
            res_v_next   = 1'b1;
            res_run_next = 1'b1;
            res_tm_next  = 1'b1;
            res_cnt_next = '0;
            state_next   = ST_IDLE;
          end else begin
            found_next = found + 1'b1;
            lbl_we     = 1'b1;
            lbl_wd     = found + 1'b1;
            q_we       = 1'b1;
            q_wa       = '0;
            q_wd       = {sz, sy, sx};
            head_next  = '0;
            tail_next  = (AW+1)'(1);
            state_next = ST_POP;
          end
        end else if (state == ST_POP && head != tail) begin
          head_next  = head + 1'b1;
          state_next = ST_POP_WAIT;
        end else begin
          // advance the raster scan or finish the run
          if (s_last) begin
            lbl_valid_next = 1'b1;
            res_v_next     = 1'b1;
            res_run_next   = 1'b1;
            res_tm_next    = 1'b0;
            res_cnt_next   = found;
            state_next     = ST_IDLE;
          end else begin
            s_next = s + 1'b1;
            if (sx == XW'(GRID_X - 1)) begin
              sx_next = '0;
              if (sy == YW'(GRID_Y - 1)) begin
                sy_next = '0;
                sz_next = sz + 1'b1;
              end else begin
                sy_next = sy + 1'b1;
              end
            end else begin
              sx_next = sx + 1'b1;
            end
            state_next = ST_SCAN;
          end
        end
      end
      ST_POP_WAIT: begin
        px_next    = q_rd[XW-1:0];
        py_next    = q_rd[XW+YW-1:XW];
        pz_next    = q_rd[QW-1:XW+YW];
        dx_next    = '0;
        dy_next    = '0;
        dz_next    = '0;
        state_next = ST_NBR;
      end
      ST_NBR, ST_NBR_CHK: begin
        occ_ra = n_idx;
        lbl_ra = n_idx;
        if (state == ST_NBR && n_ok) begin
          state_next = ST_NBR_CHK;
        end else begin
          if (state == ST_NBR_CHK && occ_rd && lbl_rd == '0) begin
            lbl_we    = 1'b1;
            lbl_wa    = n_idx;
            lbl_wd    = found;
            q_we      = 1'b1;
            tail_next = tail + 1'b1;
          end
          // advance the neighbour offset
          if (nbr_last) begin
            state_next = ST_POP;
          end else begin
            state_next = ST_NBR;
            if (dx == 2'd2) begin
              dx_next = '0;
              if (dy == 2'd2) begin
                dy_next = '0;
                dz_next = dz + 1'b1;
              end else begin
                dy_next = dy + 1'b1;
              end
            end else begin
              dx_next = dx + 1'b1;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      s            <= '0;
      conn26       <= 1'b1;
      max_cmp      <= 8'd255;
      found        <= '0;
      ovf          <= 1'b0;
      lbl_valid    <= 1'b0;
      head         <= '0;
      tail         <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      s            <= s_next;
      found        <= found_next;
      ovf          <= ovf_next;
      lbl_valid    <= lbl_valid_next;
      head         <= head_next;
      tail         <= tail_next;
      result_valid <= res_v_next;
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_CONN26: conn26  <= cfg_wdata[0];
          CFG_MAXCMP: max_cmp <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    sx    <= sx_next;
    sy    <= sy_next;
    sz    <= sz_next;
    px    <= px_next;
    py    <= py_next;
    pz    <= pz_next;
    dx    <= dx_next;
    dy    <= dy_next;
    dz    <= dz_next;
    rd_ok <= rd_ok_next;
    if (res_v_next) begin
      label           <= res_lbl_next;
      component_count <= res_cnt_next;
      too_many        <= res_tm_next;
      is_run_result   <= res_run_next;
    end
  end

endmodule

[bench/tb_voxel_connected_components_3d.sv]
// Regression bench for voxel_connected_components_3d: directed tests, then random phases.
// A software copy of the labeller predicts each read and run result. Depends on vcc3d_pkg.
module tb_voxel_connected_components_3d;
  import vcc3d_pkg::*;

  localparam int GRID_N      = 4096;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int ITEM_TARGET = 1900;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] operation;
  logic [11:0] voxel_index;
  logic       occupied;
  logic       cfg_wr_en;
  logic       cfg_addr;
  logic [7:0] cfg_wdata;
  logic       result_valid;
  logic [7:0] label;
  logic [7:0] component_count;
  logic       too_many;
  logic       is_run_result;

  typedef struct packed {
    logic [7:0] label;
    logic [7:0] count;
    logic       too_many;
    logic       is_run;
  } voxel_result_t;

  // software copy of the block state
  logic       solid_map [GRID_N];
  logic [7:0] label_map [GRID_N];
  logic [7:0] comp_found;
  logic       comp_overflow;
  logic       conn26;
  logic [7:0] comp_max;

  voxel_result_t pending_results[$];
  int  error_count;
  int  cycle_count;
  int  items_sent;
  bit  quiet;

  voxel_connected_components_3d i_dut (
    .clk, .rst, .start, .busy, .operation, .voxel_index, .occupied,
    .cfg_wr_en, .cfg_addr, .cfg_wdata, .result_valid, .label,
    .component_count, .too_many, .is_run_result
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // breadth-first labelling of the software grid
  task automatic label_grid();
    int lim;
    int walk [GRID_N];
    int head;
    int tail;
    int p;
    int x;
    int y;
    int z;
    int nx;
    int ny;
    int nz;
    int n;
    int span;
    lim = (comp_max == 8'd0) ? 1 : int'(comp_max);
    for (int i = 0; i < GRID_N; i++) label_map[i] = 8'd0;
    comp_found    = 8'd0;
    comp_overflow = 1'b0;
    for (int s = 0; s < GRID_N; s++) begin
      if (!solid_map[s] || label_map[s] != 8'd0) continue;
      if (int'(comp_found) >= lim) begin
        // one component too many: flag and wipe every label
        comp_overflow = 1'b1;
        comp_found    = 8'd0;
        for (int i = 0; i < GRID_N; i++) label_map[i] = 8'd0;
        return;
      end
      comp_found++;
      head = 0;
      tail = 0;
      label_map[s] = comp_found;
      walk[tail++] = s;
      while (head < tail) begin
        p = walk[head++];
        x = p % 16;
        y = (p / 16) % 16;
        z = p / 256;
        for (int dz = -1; dz <= 1; dz++) begin
          for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
              span = (dx != 0) + (dy != 0) + (dz != 0);
              nx = x + dx;
              ny = y + dy;
              nz = z + dz;
              if (span == 0 || (!conn26 && span != 1)) continue;
              if (nx < 0 || nx > 15 || ny < 0 || ny > 15 || nz < 0 || nz > 15) continue;
              n = nx + 16 * ny + 256 * nz;
              if (!solid_map[n] || label_map[n] != 8'd0) continue;
              label_map[n] = comp_found;
              walk[tail++] = n;
            end
          end
        end
      end
    end
  endtask

  // apply one accepted beat to the software copy and queue its result
  task automatic predict_beat(logic [1:0] op, logic [11:0] idx, logic occ);
    voxel_result_t r;
    case (op)
      OP_WRITE: begin
        solid_map[idx] = occ;
      end
      OP_RUN: begin
        label_grid();
        r = '{label: 8'd0, count: comp_found, too_many: comp_overflow, is_run: 1'b1};
        pending_results.push_back(r);
      end
      OP_READ: begin
        r = '{label: label_map[idx], count: comp_found, too_many: comp_overflow,
              is_run: 1'b0};
        pending_results.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  // send one beat, with a random gap unless in a quiet stretch
  task automatic send_beat(logic [1:0] op, logic [11:0] idx, logic occ);
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 28) begin
      start = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    operation   = op;
    voxel_index = idx;
    occupied    = occ;
    start       = 1'b1;
    do @(posedge clk); while (busy);
    predict_beat(op, idx, occ);
    items_sent++;
  endtask

  // drop start and let every result drain, then allow for a trailing write
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic addr, logic [7:0] data);
    drain();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (addr == CFG_CONN26) conn26 = data[0];
    else comp_max = data;
  endtask

  // check each result against the oldest expectation
  always @(posedge clk) begin
    voxel_result_t e;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (is_run_result !== e.is_run) begin
          $error("is_run_result expected %0d got %0d", e.is_run, is_run_result);
          error_count++;
        end
        if (label !== e.label) begin
          $error("label expected %0d got %0d", e.label, label);
          error_count++;
        end
        if (component_count !== e.count) begin
          $error("component_count expected %0d got %0d", e.count, component_count);
          error_count++;
        end
        if (too_many !== e.too_many) begin
          $error("too_many expected %0d got %0d", e.too_many, too_many);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("voxel_connected_components_3d regression: fail");
      $finish;
    end
  end

  // labels and counts are zero straight after reset
  task automatic test_reset_state();
    send_beat(OP_READ, 12'd0, 1'b0);
    send_beat(OP_READ, 12'hFFF, 1'b1);
  endtask

  // corner voxels, both flag values, ignored op code, stale labels
  task automatic test_extremes();
    send_beat(OP_WRITE, 12'd0, 1'b1);
    send_beat(OP_WRITE, 12'hFFF, 1'b1);
    send_beat(OP_WRITE, 12'd1, 1'b0);
    send_beat(OP_NONE, 12'd5, 1'b1);
    send_beat(OP_RUN, 12'd0, 1'b0);
    send_beat(OP_READ, 12'd0, 1'b0);
    send_beat(OP_READ, 12'hFFF, 1'b0);
    send_beat(OP_WRITE, 12'd0, 1'b0);
    send_beat(OP_READ, 12'd0, 1'b0);
  endtask

  // a diagonal pair joins under 26-connectivity and splits under 6
  task automatic test_connectivity();
    send_beat(OP_WRITE, 12'd0, 1'b0);
    send_beat(OP_WRITE, 12'hFFF, 1'b0);
    send_beat(OP_WRITE, 12'h111, 1'b1);
    send_beat(OP_WRITE, 12'h222, 1'b1);
    send_beat(OP_RUN, 12'd0, 1'b0);
    send_beat(OP_READ, 12'h222, 1'b0);
    write_cfg(CFG_CONN26, 8'd0);
    send_beat(OP_RUN, 12'd0, 1'b0);
    send_beat(OP_READ, 12'h222, 1'b0);
  endtask

  // one component allowed, two present: overflow, also with limit zero; limit two fits both
  task automatic test_overflow();
    write_cfg(CFG_MAXCMP, 8'd1);
    send_beat(OP_RUN, 12'd0, 1'b0);
    send_beat(OP_READ, 12'h111, 1'b0);
    write_cfg(CFG_MAXCMP, 8'd0);
    send_beat(OP_RUN, 12'd0, 1'b0);
    write_cfg(CFG_MAXCMP, 8'd2);
    send_beat(OP_RUN, 12'd0, 1'b0);
  endtask

  // isolated lattice of 512 voxels overruns the largest limit
  task automatic test_lattice_overflow();
    write_cfg(CFG_CONN26, 8'd1);
    write_cfg(CFG_MAXCMP, 8'd255);
    for (int i = 0; i < GRID_N; i++)
      if (i[0] == 0 && i[4] == 0 && i[8] == 0) send_beat(OP_WRITE, i[11:0], 1'b1);
    send_beat(OP_RUN, 12'd0, 1'b0);
    send_beat(OP_READ, 12'd0, 1'b0);
    // clear the lattice again so later runs stay short
    for (int i = 0; i < GRID_N; i++)
      if (i[0] == 0 && i[4] == 0 && i[8] == 0) send_beat(OP_WRITE, i[11:0], 1'b0);
    send_beat(OP_RUN, 12'd0, 1'b0);
  endtask

  // random phases: clustered writes in a small box, reads, noise and a closing run each, with occasional runs mid-phase
  task automatic test_random_phases();
    int bx;
    int by;
    int bz;
    int pick;
    int phase;
    logic [11:0] idx;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      write_cfg(CFG_CONN26, 8'($urandom_range(1)));
      pick = $urandom_range(3);
      write_cfg(CFG_MAXCMP, (pick == 0) ? 8'd1 : (pick == 1) ? 8'd255 :
                8'($urandom_range(255)));
      quiet = (phase % 6 == 3);
      bx = $urandom_range(12);
      by = $urandom_range(12);
      bz = $urandom_range(12);
      for (int k = 0; k < 90; k++) begin
        idx  = 12'((bx + $urandom_range(3)) + 16 * (by + $urandom_range(3)) +
                   256 * (bz + $urandom_range(3)));
        pick = $urandom_range(99);
        if (pick < 55) send_beat(OP_WRITE, idx, 1'($urandom_range(1)));
        else if (pick < 60) send_beat(OP_WRITE, 12'($urandom), 1'b0);
        else if (pick < 85) send_beat(OP_READ, idx, 1'($urandom_range(1)));
        else if (pick < 92) send_beat(OP_READ, 12'($urandom), 1'($urandom_range(1)));
        else if (pick < 96) send_beat(OP_NONE, 12'($urandom), 1'($urandom_range(1)));
        else if (k > 40) send_beat(OP_RUN, 12'($urandom), 1'($urandom_range(1)));
      end
      send_beat(OP_RUN, 12'($urandom), 1'($urandom_range(1)));
      for (int k = 0; k < 6; k++)
        send_beat(OP_READ, 12'((bx + $urandom_range(3)) + 16 * (by + $urandom_range(3)) +
                               256 * (bz + $urandom_range(3))), 1'b0);
      phase++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    operation   = OP_WRITE;
    voxel_index = 12'd0;
    occupied    = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_addr    = CFG_CONN26;
    cfg_wdata   = 8'd0;
    error_count = 0;
    cycle_count = 0;
    items_sent  = 0;
    quiet       = 1'b0;
    conn26      = 1'b1;
    comp_max    = 8'd255;
    comp_found    = 8'd0;
    comp_overflow = 1'b0;
    for (int i = 0; i < GRID_N; i++) begin
      solid_map[i] = 1'b0;
      label_map[i] = 8'd0;
    end
    repeat (5) @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_extremes();
    test_connectivity();
    test_overflow();
    test_lattice_overflow();
    test_random_phases();

    drain();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("voxel_connected_components_3d regression: pass");
    end else begin
      $display("voxel_connected_components_3d regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
sv/vcc3d_pkg.sv
sv/vcc3d_nbr.sv
sv/voxel_connected_components_3d.sv
bench/tb_voxel_connected_components_3d.sv
